FILE: src/iou_box_match_counter_core_assert.svh
// assertion macros shared by the rtl
`ifndef IOU_BOX_MATCH_COUNTER_CORE_ASSERT_SVH
`define IOU_BOX_MATCH_COUNTER_CORE_ASSERT_SVH

// condition holds at every edge outside reset
`define IOUBMC_ASSERT_HOLDS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("ioubmc assertion failed");

// consequence holds in the same cycle
`define IOUBMC_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ioubmc assertion failed");

// consequence holds in the next cycle
`define IOUBMC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ioubmc assertion failed");

`endif

FILE: src/ioubmc_pkg.sv
package ioubmc_pkg;

   localparam int FIELD_W     = 12;
   localparam int REQ_TDATA_W = 48;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 80;
   localparam int RSP_TUSER_W = 1;
   localparam int RSP_PAD_W   = 2;
   localparam int IDX_OUT_W   = 4;

   localparam int TOTAL_W     = 24;
   localparam int TOTAL_SUM_W = TOTAL_W + 1;
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

   localparam int THRESH_W = 8;
   localparam logic [THRESH_W-1:0] THRESH_RESET = 8'd128;
   localparam int THRESH_DEN = 256;

   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_REG_LSB = 2;
   localparam logic [CSR_ADDR_W-CSR_REG_LSB-1:0] REG_MATCH_THRESHOLD = '0;

   localparam logic KIND_DETECT = 1'b0;
   localparam logic KIND_TOTALS = 1'b1;

   typedef enum logic [1:0] {
      OP_LOAD   = 2'd0,
      OP_DETECT = 2'd1,
      OP_END    = 2'd2,
      OP_NONE   = 2'd3
   } opcode_type;

   typedef enum logic [13:0] {
      ST_IDLE  = 14'b00000000000001,
      ST_DAREA = 14'b00000000000010,
      ST_FETCH = 14'b00000000000100,
      ST_GEOM  = 14'b00000000001000,
      ST_MUL_I = 14'b00000000010000,
      ST_MUL_G = 14'b00000000100000,
      ST_UNION = 14'b00000001000000,
      ST_X0    = 14'b00000010000000,
      ST_X1    = 14'b00000100000000,
      ST_X2    = 14'b00001000000000,
      ST_Y1    = 14'b00010000000000,
      ST_CMP   = 14'b00100000000000,
      ST_COUNT = 14'b01000000000000,
      ST_DONE  = 14'b10000000000000
   } state_type;

endpackage

FILE: src/ioubmc_box_ram.sv
module ioubmc_box_ram #(
   parameter int DEPTH  = 16,
   parameter int ADDR_W = 4,
   parameter int DATA_W = 48
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/iou_box_match_counter_core.sv
// iou box match counter: scores detections against the truth boxes of one image.
// req channel: one word per item, tuser selects load truth box, detection or end of
// image; tdata carries the box corners. rsp channel: one word per detection (match
// flag and table index) and one per end of image (totals); loads give no word.
// csr port: apb, match_threshold at byte address 0; the user must write it only while
// idle, which the block itself does not enforce. a load is stored without leaving idle.
// a detection computes its own area once on the shared multiplier, then for each stored
// box in turn two areas and two cross products (two halves each); a box that does not
// overlap skips the multiplications and a degenerate union skips the cross products.
// an end of image walks the hit marks one per cycle. req_tready is low while an item
// is in work.
// results sit in an output register; the block takes the next item while one waits,
// and a finished item holds in its last step until the register frees.
// reset clears the table, hit marks, totals and overflow flag and sets the threshold
// to 128; the box memory is not cleared, entries are read only after being loaded.
`include "iou_box_match_counter_core_assert.svh"

module iou_box_match_counter_core #(
   parameter int MAX_TRUTH  = 16,
   parameter int COORD_BITS = 12
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // left_col, top_row, right_col, bottom_row
   input  logic [ioubmc_pkg::REQ_TDATA_W-1:0] req_tdata,
   // opcode
   input  logic [ioubmc_pkg::REQ_TUSER_W-1:0] req_tuser,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // matched, match_index, true_positives, false_positives, false_negatives,
   // table_overflow, zero fill
   output logic [ioubmc_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // result_kind
   output logic [ioubmc_pkg::RSP_TUSER_W-1:0] rsp_tuser,
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [ioubmc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [ioubmc_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [ioubmc_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic csr_pready
);

   import ioubmc_pkg::*;

   localparam int CW      = COORD_BITS;
   localparam int SPAN_W  = CW + 1;
   localparam int AREA_W  = 2 * SPAN_W;
   localparam int UNI_W   = AREA_W + 1;
   localparam int LIMB_W  = SPAN_W + 1;
   localparam int MP_W    = AREA_W + LIMB_W;
   localparam int CROSS_W = MP_W + LIMB_W;
   localparam int CNT_W   = $clog2(MAX_TRUTH + 1);
   localparam int IDX_W   = (MAX_TRUTH > 1) ? $clog2(MAX_TRUTH) : 1;
   localparam int BOX_W   = 4 * CW;

   function automatic logic [SPAN_W-1:0] span(input logic [CW-1:0] a, input logic [CW-1:0] b);
      logic [CW-1:0] diff;
      diff = (a > b) ? a - b : b - a;
      return {1'b0, diff} + SPAN_W'(1);
   endfunction

   state_type state_ff, state_in;
   logic [THRESH_W-1:0] thresh_ff, thresh_in;
   logic [CNT_W-1:0] truth_count_ff, truth_count_in;
   logic overflow_ff, overflow_in;
   logic [MAX_TRUTH-1:0] hit_marks_ff, hit_marks_in;
   logic [TOTAL_W-1:0] tp_ff, tp_in, fp_ff, fp_in, fn_ff, fn_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic [CW-1:0] det_l_ff, det_l_in, det_t_ff, det_t_in;
   logic [CW-1:0] det_r_ff, det_r_in, det_b_ff, det_b_in;
   logic [CNT_W-1:0] i_ff, i_in, hits_ff, hits_in;
   logic [SPAN_W-1:0] iw_ff, iw_in, ih_ff, ih_in, gw_ff, gw_in, gh_ff, gh_in;
   logic [AREA_W-1:0] ad_ff, ad_in, ai_ff, ai_in, ag_ff, ag_in, bn_ff, bn_in;
   logic [UNI_W-1:0] uni_ff, uni_in, bd_ff, bd_in;
   logic [MP_W-1:0] acc_ff, acc_in, prod_ff, prod_in;
   logic [CROSS_W-1:0] x_ff, x_in;
   logic [IDX_W-1:0] best_idx_ff, best_idx_in;
   logic matched_ff, matched_in, item_kind_ff, item_kind_in;

   logic rsp_kind_ff, rsp_kind_in, rsp_matched_ff, rsp_matched_in, rsp_ovf_ff, rsp_ovf_in;
   logic [IDX_OUT_W-1:0] rsp_idx_ff, rsp_idx_in;
   logic [TOTAL_W-1:0] rsp_tp_ff, rsp_tp_in, rsp_fp_ff, rsp_fp_in, rsp_fn_ff, rsp_fn_in;

   logic req_fire, out_load, last_box, no_ovl, ram_wr_en, ram_rd_en;
   opcode_type req_op;
   logic [CW-1:0] req_l, req_t, req_r, req_b, g_l, g_t, g_r, g_b;
   logic [BOX_W-1:0] ram_rd_data;
   logic [CNT_W-1:0] i_next;
   logic [AREA_W-1:0] mul_a;
   logic [LIMB_W-1:0] mul_b;
   logic [MP_W-1:0] mul_p;
   logic [UNI_W-1:0] uni_sum;
   logic [CROSS_W-1:0] cross_sum;
   logic [TOTAL_SUM_W-1:0] tp_sum, fn_sum;
   logic [TOTAL_W-1:0] tp_sat, fn_sat, fp_sat;
   logic [CNT_W-1:0] misses;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign req_op     = opcode_type'(req_tuser[1:0]);
   assign req_l = CW'(req_tdata[FIELD_W-1:0]);
   assign req_t = CW'(req_tdata[2*FIELD_W-1:FIELD_W]);
   assign req_r = CW'(req_tdata[3*FIELD_W-1:2*FIELD_W]);
   assign req_b = CW'(req_tdata[4*FIELD_W-1:3*FIELD_W]);

   ioubmc_box_ram #(
      .DEPTH (MAX_TRUTH),
      .ADDR_W(IDX_W),
      .DATA_W(BOX_W)
   ) u_box_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(truth_count_ff[IDX_W-1:0]),
      .wr_data({req_b, req_r, req_t, req_l}),
      .rd_en  (ram_rd_en),
      .rd_addr(i_ff[IDX_W-1:0]),
      .rd_data(ram_rd_data)
   );

   assign g_l = ram_rd_data[CW-1:0];
   assign g_t = ram_rd_data[2*CW-1:CW];
   assign g_r = ram_rd_data[3*CW-1:2*CW];
   assign g_b = ram_rd_data[4*CW-1:3*CW];
   assign no_ovl = (det_l_ff > g_r) || (det_r_ff < g_l) || (det_t_ff > g_b) || (det_b_ff < g_t);

   // shared multiplier
   always_comb begin
      unique case (state_ff)
         ST_DAREA: begin
            mul_a = AREA_W'(span(det_r_ff, det_l_ff));
            mul_b = LIMB_W'(span(det_b_ff, det_t_ff));
         end
         ST_MUL_I: begin
            mul_a = AREA_W'(iw_ff);
            mul_b = LIMB_W'(ih_ff);
         end
         ST_MUL_G: begin
            mul_a = AREA_W'(gw_ff);
            mul_b = LIMB_W'(gh_ff);
         end
         ST_X0: begin
            mul_a = ai_ff;
            mul_b = bd_ff[LIMB_W-1:0];
         end
         ST_X1: begin
            mul_a = ai_ff;
            mul_b = LIMB_W'(bd_ff[UNI_W-1:LIMB_W]);
         end
         ST_X2: begin
            mul_a = bn_ff;
            mul_b = uni_ff[LIMB_W-1:0];
         end
         ST_Y1: begin
            mul_a = bn_ff;
            mul_b = LIMB_W'(uni_ff[UNI_W-1:LIMB_W]);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p     = MP_W'(mul_a) * MP_W'(mul_b);
   assign uni_sum   = {1'b0, ad_ff} + {1'b0, ag_ff};
   assign cross_sum = CROSS_W'(acc_ff) + {prod_ff, {LIMB_W{1'b0}}};
   assign i_next    = i_ff + CNT_W'(1);
   assign last_box  = (i_next == truth_count_ff);

   assign misses = truth_count_ff - hits_ff;
   assign tp_sum = TOTAL_SUM_W'(tp_ff) + TOTAL_SUM_W'(hits_ff);
   assign fn_sum = TOTAL_SUM_W'(fn_ff) + TOTAL_SUM_W'(misses);
   assign tp_sat = (tp_sum > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : tp_sum[TOTAL_W-1:0];
   assign fn_sat = (fn_sum > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : fn_sum[TOTAL_W-1:0];
   assign fp_sat = (fp_ff == TOTAL_MAX) ? fp_ff : fp_ff + TOTAL_W'(1);

   always_comb begin
      state_in = state_ff;
      thresh_in = thresh_ff;
      truth_count_in = truth_count_ff;
      overflow_in = overflow_ff;
      hit_marks_in = hit_marks_ff;
      tp_in = tp_ff;
      fp_in = fp_ff;
      fn_in = fn_ff;
      det_l_in = det_l_ff;
      det_t_in = det_t_ff;
      det_r_in = det_r_ff;
      det_b_in = det_b_ff;
      i_in = i_ff;
      hits_in = hits_ff;
      iw_in = iw_ff;
      ih_in = ih_ff;
      gw_in = gw_ff;
      gh_in = gh_ff;
      ad_in = ad_ff;
      ai_in = ai_ff;
      ag_in = ag_ff;
      bn_in = bn_ff;
      uni_in = uni_ff;
      bd_in = bd_ff;
      acc_in = acc_ff;
      prod_in = prod_ff;
      x_in = x_ff;
      best_idx_in = best_idx_ff;
      matched_in = matched_ff;
      item_kind_in = item_kind_ff;
      ram_wr_en = 1'b0;
      ram_rd_en = 1'b0;
      out_load = 1'b0;
      rsp_kind_in = rsp_kind_ff;
      rsp_matched_in = rsp_matched_ff;
      rsp_idx_in = rsp_idx_ff;
      rsp_tp_in = rsp_tp_ff;
      rsp_fp_in = rsp_fp_ff;
      rsp_fn_in = rsp_fn_ff;
      rsp_ovf_in = rsp_ovf_ff;

      if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
          csr_paddr[CSR_ADDR_W-1:CSR_REG_LSB] == REG_MATCH_THRESHOLD) begin
         thresh_in = csr_pwdata[THRESH_W-1:0];
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               det_l_in = req_l;
               det_t_in = req_t;
               det_r_in = req_r;
               det_b_in = req_b;
               i_in = '0;
               hits_in = '0;
               matched_in = 1'b0;
               best_idx_in = '0;
               bn_in = AREA_W'(thresh_ff);
               bd_in = UNI_W'(THRESH_DEN);
               unique case (req_op)
                  OP_LOAD: begin
                     if (truth_count_ff < CNT_W'(MAX_TRUTH)) begin
                        ram_wr_en = 1'b1;
                        hit_marks_in[truth_count_ff[IDX_W-1:0]] = 1'b0;
                        truth_count_in = truth_count_ff + CNT_W'(1);
                     end else begin
                        overflow_in = 1'b1;
                     end
                  end
                  OP_DETECT: begin
                     item_kind_in = KIND_DETECT;
                     state_in = ST_DAREA;
                  end
                  OP_END: begin
                     item_kind_in = KIND_TOTALS;
                     state_in = (truth_count_ff == '0) ? ST_DONE : ST_COUNT;
                  end
                  OP_NONE: begin
                  end
               endcase
            end
         end
         ST_DAREA: begin
            ad_in = mul_p[AREA_W-1:0];
            state_in = (truth_count_ff == '0) ? ST_DONE : ST_FETCH;
         end
         ST_FETCH: begin
            ram_rd_en = 1'b1;
            state_in = ST_GEOM;
         end
         ST_GEOM: begin
            iw_in = span((det_r_ff < g_r) ? det_r_ff : g_r, (det_l_ff > g_l) ? det_l_ff : g_l);
            ih_in = span((det_b_ff < g_b) ? det_b_ff : g_b, (det_t_ff > g_t) ? det_t_ff : g_t);
            gw_in = span(g_r, g_l);
            gh_in = span(g_b, g_t);
            if (no_ovl) begin
               i_in = i_next;
               state_in = last_box ? ST_DONE : ST_FETCH;
            end else begin
               state_in = ST_MUL_I;
            end
         end
         ST_MUL_I: begin
            ai_in = mul_p[AREA_W-1:0];
            state_in = ST_MUL_G;
         end
         ST_MUL_G: begin
            ag_in = mul_p[AREA_W-1:0];
            state_in = ST_UNION;
         end
         ST_UNION: begin
            // degenerate union scores zero
            if ({1'b0, ai_ff} >= uni_sum) begin
               i_in = i_next;
               state_in = last_box ? ST_DONE : ST_FETCH;
            end else begin
               uni_in = uni_sum - {1'b0, ai_ff};
               state_in = ST_X0;
            end
         end
         ST_X0: begin
            acc_in = mul_p;
            state_in = ST_X1;
         end
         ST_X1: begin
            prod_in = mul_p;
            state_in = ST_X2;
         end
         ST_X2: begin
            x_in = cross_sum;
            acc_in = mul_p;
            state_in = ST_Y1;
         end
         ST_Y1: begin
            prod_in = mul_p;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (x_ff > cross_sum) begin
               bn_in = ai_ff;
               bd_in = uni_ff;
               matched_in = 1'b1;
               best_idx_in = i_ff[IDX_W-1:0];
            end
            i_in = i_next;
            state_in = last_box ? ST_DONE : ST_FETCH;
         end
         ST_COUNT: begin
            hits_in = hits_ff + CNT_W'(hit_marks_ff[i_ff[IDX_W-1:0]]);
            i_in = i_next;
            state_in = last_box ? ST_DONE : ST_COUNT;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
               rsp_kind_in = item_kind_ff;
               rsp_ovf_in = overflow_ff;
               rsp_tp_in = tp_ff;
               rsp_fp_in = fp_ff;
               rsp_fn_in = fn_ff;
               if (item_kind_ff == KIND_DETECT) begin
                  rsp_matched_in = matched_ff;
                  rsp_idx_in = matched_ff ? IDX_OUT_W'(best_idx_ff) : '0;
                  if (matched_ff) begin
                     hit_marks_in[best_idx_ff] = 1'b1;
                  end else begin
                     fp_in = fp_sat;
                     rsp_fp_in = fp_sat;
                  end
               end else begin
                  rsp_matched_in = 1'b0;
                  rsp_idx_in = '0;
                  tp_in = tp_sat;
                  fn_in = fn_sat;
                  rsp_tp_in = tp_sat;
                  rsp_fn_in = fn_sat;
                  truth_count_in = '0;
                  overflow_in = 1'b0;
                  hit_marks_in = '0;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = out_load ? 1'b1 : (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         thresh_ff <= THRESH_RESET;
         truth_count_ff <= '0;
         overflow_ff <= 1'b0;
         hit_marks_ff <= '0;
         tp_ff <= '0;
         fp_ff <= '0;
         fn_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         thresh_ff <= thresh_in;
         truth_count_ff <= truth_count_in;
         overflow_ff <= overflow_in;
         hit_marks_ff <= hit_marks_in;
         tp_ff <= tp_in;
         fp_ff <= fp_in;
         fn_ff <= fn_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      det_l_ff <= det_l_in;
      det_t_ff <= det_t_in;
      det_r_ff <= det_r_in;
      det_b_ff <= det_b_in;
      i_ff <= i_in;
      hits_ff <= hits_in;
      iw_ff <= iw_in;
      ih_ff <= ih_in;
      gw_ff <= gw_in;
      gh_ff <= gh_in;
      ad_ff <= ad_in;
      ai_ff <= ai_in;
      ag_ff <= ag_in;
      bn_ff <= bn_in;
      uni_ff <= uni_in;
      bd_ff <= bd_in;
      acc_ff <= acc_in;
      prod_ff <= prod_in;
      x_ff <= x_in;
      best_idx_ff <= best_idx_in;
      matched_ff <= matched_in;
      item_kind_ff <= item_kind_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_matched_ff <= rsp_matched_in;
      rsp_idx_ff <= rsp_idx_in;
      rsp_tp_ff <= rsp_tp_in;
      rsp_fp_ff <= rsp_fp_in;
      rsp_fn_ff <= rsp_fn_in;
      rsp_ovf_ff <= rsp_ovf_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = {RSP_PAD_W'(0), rsp_ovf_ff, rsp_fn_ff, rsp_fp_ff, rsp_tp_ff,
                        rsp_idx_ff, rsp_matched_ff};

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[CSR_ADDR_W-1:CSR_REG_LSB] == REG_MATCH_THRESHOLD) ?
                       CSR_DATA_W'(thresh_ff) : '0;

   `IOUBMC_ASSERT_HOLDS(a_count_in_range, clock, reset, truth_count_ff <= CNT_W'(MAX_TRUTH))
   `IOUBMC_ASSERT_IMPLIES(a_match_has_hit, clock, reset,
      rsp_valid_ff && rsp_kind_ff == KIND_DETECT && rsp_matched_ff, hit_marks_ff != '0)
   `IOUBMC_ASSERT_NEXT(a_totals_clear_table, clock, reset,
      out_load && item_kind_ff == KIND_TOTALS,
      truth_count_ff == '0 && hit_marks_ff == '0 && !overflow_ff)

endmodule
